// ===== hdl/mis_pkg.sv =====
package mis_pkg;

   // Largest graph the datapath is built for; a larger vertex count clamps here.
   localparam int MAX_VERTICES = 8;
   localparam int MASK_W       = 28;
   localparam int VCNT_W       = 4;
   localparam int COUNT_W      = 8;
   localparam int SUBSET_W     = MAX_VERTICES;
   localparam int REQ_DATA_W   = 32;
   localparam int RSP_DATA_W   = 48;

   localparam logic [VCNT_W-1:0]  VCNT_RESET = VCNT_W'(4);
   localparam logic [COUNT_W-1:0] COUNT_MAX  = {COUNT_W{1'b1}};

   typedef logic [MAX_VERTICES-1:0] nbr_type;
   typedef nbr_type [MAX_VERTICES-1:0] adj_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_FLUSH
   } st_type;

   // Clamp the programmed vertex count to what the datapath holds.
   function automatic logic [VCNT_W-1:0] clamp_vcount(logic [VCNT_W-1:0] vc);
      if (int'(vc) > MAX_VERTICES) begin
         return VCNT_W'(MAX_VERTICES);
      end
      return vc;
   endfunction

   // Neighbor masks. The bit of pair (i,j) moves with the vertex count, so
   // every count has its own fixed wiring and the active one is selected.
   function automatic adj_type build_adj(logic [VCNT_W-1:0] n,
                                         logic [MASK_W-1:0] edges);
      adj_type adj;
      int      k;
      adj = '0;
      for (int nn = 2; nn <= MAX_VERTICES; nn++) begin
         for (int i = 0; i < MAX_VERTICES; i++) begin
            for (int j = 0; j < MAX_VERTICES; j++) begin
               k = i * nn - ((i * (i + 1)) >> 1) + j - i - 1;
               if (int'(n) == nn && i < j && j < nn && k < MASK_W) begin
                  if (edges[5'(k)]) begin
                     adj[i][j] = 1'b1;
                     adj[j][i] = 1'b1;
                  end
               end
            end
         end
      end
      return adj;
   endfunction

   // Mask of the edge bits that carry a pair for this vertex count.
   function automatic logic [MASK_W-1:0] used_mask(logic [VCNT_W-1:0] n);
      logic [MASK_W-1:0] m;
      int                pairs;
      pairs = (int'(n) * (int'(n) - 1)) >> 1;
      for (int k = 0; k < MASK_W; k++) begin
         m[k] = (k < pairs);
      end
      return m;
   endfunction

endpackage

// ===== hdl/maximal_independent_set_counter_unit.sv =====
// Channel | Dir | Handshake            | Content
// req     | in  | req_tvalid/tready    | tdata: edge_mask; tlast: batch_end
// rsp     | out | rsp_tvalid/tready    | tdata: set_count, best_count, best_graph;
//         |     |                      | tlast: is_last
// csr     | in  | csr_we               | csr_wdata: vertex_count
//
// A word is handled in steps, n being the clamped vertex count: the graph is latched,
// its 2^n subsets go one subset per cycle through the shared subset checker, and then the
// batch maximum is updated and the output register loaded.
// Reset (synchronous) sets the vertex count to 4 and clears the batch maximum.
// A stalled rsp holds the finished word; the next graph may be counted
// meanwhile and waits in the flush state until the output register frees up.
module maximal_independent_set_counter_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [mis_pkg::REQ_DATA_W-1:0]    req_tdata,  // [27:0] edge_mask
   input  logic                              req_tlast,  // batch_end
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [mis_pkg::RSP_DATA_W-1:0]    rsp_tdata,  // [7:0] set_count,
                                                         // [15:8] best_count,
                                                         // [43:16] best_graph
   output logic                              rsp_tlast,  // is_last
   input  logic                              csr_we,
   input  logic [mis_pkg::VCNT_W-1:0]        csr_wdata   // vertex_count
);
   import mis_pkg::*;

   st_type               state_ff, state_in;
   logic [VCNT_W-1:0]    vcount_ff, vcount_in;
   logic [VCNT_W-1:0]    n_ff, n_in;
   adj_type              adj_ff, adj_in;
   logic [MASK_W-1:0]    graph_ff, graph_in;
   logic                 last_ff, last_in;
   logic [SUBSET_W-1:0]  subset_ff, subset_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [COUNT_W-1:0]   best_ff, best_in;
   logic [MASK_W-1:0]    best_graph_ff, best_graph_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic                 accept, step, load_out, out_free, last_subset, is_mis;
   logic [VCNT_W-1:0]    n_req;
   logic [SUBSET_W-1:0]  full_mask;
   logic [COUNT_W-1:0]   new_best;
   logic [MASK_W-1:0]    new_best_graph;

   assign accept   = req_tvalid & req_tready;
   assign out_free = ~rsp_valid_ff | rsp_tready;
   assign n_req    = clamp_vcount(vcount_ff);

   // Last subset index is 2^n - 1; n = 0 leaves only the empty set.
   assign full_mask   = SUBSET_W'(({1'b0, {SUBSET_W{1'b0}}} | (SUBSET_W+1)'(1) << n_ff)
                                  - (SUBSET_W+1)'(1));
   assign last_subset = (subset_ff == full_mask);

   mis_subset_check u_check (
      .adj    (adj_ff),
      .subset (subset_ff),
      .n      (n_ff),
      .is_mis (is_mis)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (accept) begin
            state_in = ST_RUN;
         end
         ST_RUN:   if (last_subset) begin
            state_in = ST_FLUSH;
         end
         ST_FLUSH: if (out_free) begin
            state_in = ST_IDLE;
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs
   always_comb begin
      req_tready = 1'b0;
      step       = 1'b0;
      load_out   = 1'b0;
      unique case (state_ff)
         ST_IDLE:  req_tready = 1'b1;
         ST_RUN:   step       = 1'b1;
         ST_FLUSH: load_out   = out_free;
         default:  req_tready = 1'b0;
      endcase
   end

   // Batch maximum: replace only on a strictly greater count.
   always_comb begin
      if (count_ff > best_ff) begin
         new_best       = count_ff;
         new_best_graph = graph_ff;
      end else begin
         new_best       = best_ff;
         new_best_graph = best_graph_ff;
      end
   end

   // Datapath
   always_comb begin
      vcount_in     = csr_we ? csr_wdata : vcount_ff;
      n_in          = n_ff;
      adj_in        = adj_ff;
      graph_in      = graph_ff;
      last_in       = last_ff;
      subset_in     = subset_ff;
      count_in      = count_ff;
      best_in       = best_ff;
      best_graph_in = best_graph_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_tready;

      if (accept) begin
         // latch the graph in the layout of the current vertex count
         n_in      = n_req;
         adj_in    = build_adj(n_req, req_tdata[MASK_W-1:0]);
         graph_in  = req_tdata[MASK_W-1:0] & used_mask(n_req);
         last_in   = req_tlast;
         subset_in = '0;
         count_in  = '0;
      end

      if (step) begin
         // advance one subset, saturate the count
         subset_in = subset_ff + SUBSET_W'(1);
         if (is_mis && count_ff != COUNT_MAX) begin
            count_in = count_ff + COUNT_W'(1);
         end
      end

      if (load_out) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = RSP_DATA_W'({new_best_graph, new_best, count_ff});
         rsp_last_in  = last_ff;
         // drop the maximum once the batch closes
         best_in       = last_ff ? '0 : new_best;
         best_graph_in = last_ff ? '0 : new_best_graph;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         vcount_ff     <= VCNT_RESET;
         best_ff       <= '0;
         best_graph_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         vcount_ff     <= vcount_in;
         best_ff       <= best_in;
         best_graph_ff <= best_graph_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      n_ff        <= n_in;
      adj_ff      <= adj_in;
      graph_ff    <= graph_in;
      last_ff     <= last_in;
      subset_ff   <= subset_in;
      count_ff    <= count_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // Subset index stays within the vertices of the graph.
   a_subset_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RUN |-> (subset_ff & ~full_mask) == '0)
      else $error("subset index beyond vertex count");

   // An accepted graph starts counting next cycle.
   a_accept_run: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_RUN && subset_ff == '0 && count_ff == '0)
      else $error("accepted graph did not start counting");

   // Count never drops while subsets are walked.
   a_count_mono: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RUN |=> count_ff >= $past(count_ff))
      else $error("set count decreased");

   // Reported maximum covers the graph it reports with.
   a_best_ge: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_data_ff[2*COUNT_W-1:COUNT_W] >= rsp_data_ff[COUNT_W-1:0])
      else $error("best count below set count");

endmodule

// ===== hdl/mis_subset_check.sv =====
module mis_subset_check (
   input  mis_pkg::adj_type                   adj,
   input  logic [mis_pkg::SUBSET_W-1:0]       subset,
   input  logic [mis_pkg::VCNT_W-1:0]         n,
   output logic                               is_mis
);
   import mis_pkg::*;

   logic [MAX_VERTICES-1:0] vtx_ok;

   // A vertex inside must have no neighbor inside; one outside must have one.
   always_comb begin
      for (int v = 0; v < MAX_VERTICES; v++) begin
         if (v < int'(n)) begin
            vtx_ok[v] = subset[v] ^ (|(adj[v] & subset));
         end else begin
            vtx_ok[v] = 1'b1;
         end
      end
   end

   assign is_mis = &vtx_ok;

endmodule
